// ----- src/prot_pkg.sv -----
// ----------------------------------------------------------------------------
// prot_pkg
// Shared types, constants and the sine table builder for point_rotate_xyz.
// ----------------------------------------------------------------------------
package prot_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned ANGLE_W         = 9;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned TRIG_FRAC_DEF   = 14;
  localparam int unsigned TRIG_MAG_W      = 17;
  localparam int unsigned QUARTER_ENTRIES = 91;
  localparam int unsigned TAB_IDX_W       = 7;
  localparam int unsigned PLANE_STAGES    = 2;
  localparam int unsigned PIPE_LAT        = 1 + 3 * PLANE_STAGES;
  localparam logic [63:0] DEC_SCALE       = 64'd10000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } cfg_reg_t;

  typedef logic [TRIG_MAG_W-1:0] trig_mag_t;
  typedef trig_mag_t sine_tab_t [0:QUARTER_ENTRIES-1];

  typedef struct packed {
    logic [TAB_IDX_W-1:0] idx;
    logic                 neg;
  } trig_sel_t;

  // sin(k deg) * 1e7, k = 0..90
  localparam logic [23:0] SINE_DEC [0:QUARTER_ENTRIES-1] = '{
    24'd0, 24'd174524, 24'd348995, 24'd523360, 24'd697565, 24'd871557,
    24'd1045285, 24'd1218693, 24'd1391731, 24'd1564345, 24'd1736482,
    24'd1908090, 24'd2079117, 24'd2249511, 24'd2419219, 24'd2588190,
    24'd2756374, 24'd2923717, 24'd3090170, 24'd3255682, 24'd3420201,
    24'd3583679, 24'd3746066, 24'd3907311, 24'd4067366, 24'd4226183,
    24'd4383711, 24'd4539905, 24'd4694716, 24'd4848096, 24'd5000000,
    24'd5150381, 24'd5299193, 24'd5446390, 24'd5591929, 24'd5735764,
    24'd5877853, 24'd6018150, 24'd6156615, 24'd6293204, 24'd6427876,
    24'd6560590, 24'd6691306, 24'd6819984, 24'd6946584, 24'd7071068,
    24'd7193398, 24'd7313537, 24'd7431448, 24'd7547096, 24'd7660444,
    24'd7771460, 24'd7880108, 24'd7986355, 24'd8090170, 24'd8191520,
    24'd8290376, 24'd8386706, 24'd8480481, 24'd8571673, 24'd8660254,
    24'd8746197, 24'd8829476, 24'd8910065, 24'd8987940, 24'd9063078,
    24'd9135455, 24'd9205049, 24'd9271839, 24'd9335804, 24'd9396926,
    24'd9455186, 24'd9510565, 24'd9563048, 24'd9612617, 24'd9659258,
    24'd9702957, 24'd9743701, 24'd9781476, 24'd9816272, 24'd9848078,
    24'd9876883, 24'd9902681, 24'd9925462, 24'd9945219, 24'd9961947,
    24'd9975641, 24'd9986295, 24'd9993908, 24'd9998477, 24'd10000000
  };

  // quarter-wave table in Q1.frac, rounded half up
  function automatic sine_tab_t build_sine_tab(input int unsigned frac);
    sine_tab_t   t;
    logic [63:0] v;
    for (int k = 0; k < QUARTER_ENTRIES; k++) begin
      v    = (64'(SINE_DEC[k]) << frac) + (DEC_SCALE >> 1);
      t[k] = trig_mag_t'(v / DEC_SCALE);
    end
    return t;
  endfunction

  // one subtraction of 360
  function automatic logic [ANGLE_W-1:0] reduce_angle(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] r;
    r = a;
    if (a >= 9'd360) begin
      r = a - 9'd360;
    end
    return r;
  endfunction

  // quadrant folding for sine of d in 0..359
  function automatic trig_sel_t sine_sel(input logic [ANGLE_W:0] d);
    trig_sel_t      s;
    logic [ANGLE_W:0] t;
    t = d;
    s.neg = 1'b0;
    if (d <= 10'd90) begin
      t = d;
    end else if (d <= 10'd180) begin
      t = 10'd180 - d;
    end else if (d <= 10'd270) begin
      t = d - 10'd180;
      s.neg = 1'b1;
    end else begin
      t = 10'd360 - d;
      s.neg = 1'b1;
    end
    s.idx = t[TAB_IDX_W-1:0];
    return s;
  endfunction

  // cosine via sine of d + 90, wrapped
  function automatic trig_sel_t cosine_sel(input logic [ANGLE_W-1:0] d);
    logic [ANGLE_W:0] e;
    e = {1'b0, d} + 10'd90;
    if (e >= 10'd360) begin
      e = e - 10'd360;
    end
    return sine_sel(e);
  endfunction

endpackage

// ----- src/point_rotate_xyz.sv -----
// ----------------------------------------------------------------------------
// point_rotate_xyz
// Rotates a Q16.16 point about x, then y, then z by configured whole degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_x_in/in_y_in/in_z_in and pulse start; an item is taken at
//   each edge with start high and busy low. busy stays low, so one item can
//   enter every cycle.
//   Output: out_valid is high for one cycle with out_x_out/out_y_out/out_z_out.
//   The receiver cannot stall; results appear in accept order.
//   Pipeline: an accepted item passes the input register, then two stages
//   per axis (multiply, then round/saturate), before the result is taken.
//   Throughput: one item per cycle.
//   Configuration: cfg_index 0/1/2 selects the x/y/z angle, cfg_data holds
//   the angle (values 360..511 wrap by one subtraction of 360). cfg_ready is
//   always high; index 3 is ignored. Write angles only while no item is in
//   flight. Sine/cosine are registered in the cycle after a write.
//   Reset: synchronous, rst_n low; clears angles to 0 and all valid bits.
// ----------------------------------------------------------------------------
module point_rotate_xyz
  import prot_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_x_in,
  input  logic signed [COORD_W-1:0] in_y_in,
  input  logic signed [COORD_W-1:0] in_z_in,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_x_out,
  output logic signed [COORD_W-1:0] out_y_out,
  output logic signed [COORD_W-1:0] out_z_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [ANGLE_W-1:0]        cfg_data
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam sine_tab_t SINE_TAB = build_sine_tab(TRIG_FRAC_BITS);

  logic [ANGLE_W-1:0]   angle_r   [3];
  logic signed [TW-1:0] sin_r     [3];
  logic signed [TW-1:0] cos_r     [3];
  logic signed [TW-1:0] sin_nxt   [3];
  logic signed [TW-1:0] cos_nxt   [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // angle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r[0] <= '0;
      angle_r[1] <= '0;
      angle_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_X: angle_r[0] <= cfg_data;
        REG_ANGLE_Y: angle_r[1] <= cfg_data;
        REG_ANGLE_Z: angle_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sine/cosine lookup, refreshed every cycle
  always_comb begin
    logic [ANGLE_W-1:0]   d;
    trig_sel_t            ss, cs;
    logic signed [TW-1:0] sv, cv;
    for (int i = 0; i < 3; i++) begin
      d  = reduce_angle(angle_r[i]);
      ss = sine_sel({1'b0, d});
      cs = cosine_sel(d);
      sv = signed'({1'b0, SINE_TAB[ss.idx][TRIG_FRAC_BITS:0]});
      cv = signed'({1'b0, SINE_TAB[cs.idx][TRIG_FRAC_BITS:0]});
      sin_nxt[i] = ss.neg ? -sv : sv;
      cos_nxt[i] = cs.neg ? -cv : cv;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sin_r[i] <= sin_nxt[i];
      cos_r[i] <= cos_nxt[i];
    end
  end

  // input register
  logic                      v0_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= in_x_in;
    y0_r <= in_y_in;
    z0_r <= in_z_in;
  end

  // about x: (y,z), x rides along
  logic                      v_ax;
  logic signed [COORD_W-1:0] x_ax, y_ax, z_ax;

  prot_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .a_in      (y0_r),
    .b_in      (z0_r),
    .p_in      (x0_r),
    .sin_in    (sin_r[0]),
    .cos_in    (cos_r[0]),
    .out_valid (v_ax),
    .a_out     (y_ax),
    .b_out     (z_ax),
    .p_out     (x_ax)
  );

  // about y: (x,z), y rides along
  logic                      v_ay;
  logic signed [COORD_W-1:0] x_ay, y_ay, z_ay;

  prot_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_ax),
    .a_in      (x_ax),
    .b_in      (z_ax),
    .p_in      (y_ax),
    .sin_in    (sin_r[1]),
    .cos_in    (cos_r[1]),
    .out_valid (v_ay),
    .a_out     (x_ay),
    .b_out     (z_ay),
    .p_out     (y_ay)
  );

  // about z: (x,y), z rides along
  prot_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_ay),
    .a_in      (x_ay),
    .b_in      (y_ay),
    .p_in      (z_ay),
    .sin_in    (sin_r[2]),
    .cos_in    (cos_r[2]),
    .out_valid (out_valid),
    .a_out     (out_x_out),
    .b_out     (out_y_out),
    .p_out     (out_z_out)
  );

  // every result traces back to an earlier accepted item
  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching item");

  // every accepted item yields a result
  a_item_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("item lost in pipeline");

  // sine and cosine of a whole-degree angle are never both zero
  a_trig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |=> ((sin_r[0] != '0 || cos_r[0] != '0) &&
                      (sin_r[1] != '0 || cos_r[1] != '0) &&
                      (sin_r[2] != '0 || cos_r[2] != '0)))
    else $error("sine/cosine lookup both zero");

endmodule

// ----- src/prot_plane.sv -----
// ----------------------------------------------------------------------------
// prot_plane
// Two-stage plane rotation: a' = a*c - b*s, b' = a*s + b*c, rounded half up
// and saturated to 32 bits. A third coordinate rides along untouched.
// ----------------------------------------------------------------------------
module prot_plane
  import prot_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [COORD_W-1:0]          a_in,
  input  logic signed [COORD_W-1:0]          b_in,
  input  logic signed [COORD_W-1:0]          p_in,
  input  logic signed [TRIG_FRAC_BITS+1:0]   sin_in,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cos_in,
  output logic                               out_valid,
  output logic signed [COORD_W-1:0]          a_out,
  output logic signed [COORD_W-1:0]          b_out,
  output logic signed [COORD_W-1:0]          p_out
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW = COORD_W + TW;
  localparam int unsigned SW = PW + 1;
  localparam logic signed [SW-1:0] HALF =
    {{(SW-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALF) >>> TRIG_FRAC_BITS;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[COORD_W-1:0];
  endfunction

  // stage 1: products
  logic                      v1_r;
  logic signed [PW-1:0]      ac_r, bs_r, as_r, bc_r;
  logic signed [COORD_W-1:0] p1_r;

  // stage 2: sums, round, saturate
  logic                      v2_r;
  logic signed [COORD_W-1:0] a2_r, b2_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r <= a_in * cos_in;
    bs_r <= b_in * sin_in;
    as_r <= a_in * sin_in;
    bc_r <= b_in * cos_in;
    p1_r <= p_in;
    a2_r <= round_sat(SW'(ac_r) - SW'(bs_r));
    b2_r <= round_sat(SW'(as_r) + SW'(bc_r));
    p2_r <= p1_r;
  end

  assign out_valid = v2_r;
  assign a_out     = a2_r;
  assign b_out     = b2_r;
  assign p_out     = p2_r;

endmodule
